// ----- hw/rtl/ibm_pkg.sv -----
// Shared types and constants of the I2C bit-level master.
package ibm_pkg;

    localparam int unsigned OP_W      = 3;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 8;
    localparam int unsigned S_DATA_W  = 16;
    localparam int unsigned M_DATA_W  = 16;
    localparam int unsigned DELAY_W   = 12;

    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_WAIT  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT  = 1'd1;

    localparam logic [CFG_DAT_W-1:0] TICKS_RESET       = 8'd1;
    localparam logic [CFG_DAT_W-1:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [BYTE_W-1:0]    MSB_MASK          = 8'h80;

    typedef struct packed {
        logic              scl_level;
        logic              sda_release;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              no_ack;
    } res_t;

endpackage

// ----- hw/rtl/ibm_seq.sv -----
// Bus step sequencer: sequence state and one-tick next-state logic.
module ibm_seq
    import ibm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [OP_W-1:0]      op,
    input  logic [BYTE_W-1:0]    tx_byte,
    input  logic                 ack_after_read,
    input  logic                 sda_level,
    input  logic [CFG_DAT_W-1:0] ticks_per_us,
    input  logic [CFG_DAT_W-1:0] ack_timeout,
    output res_t                 res
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_START_A, ST_START_B, ST_STOP_A, ST_STOP_B, ST_STOP_C,
        ST_TSTOP_A, ST_TSTOP_B, ST_TSTOP_C, ST_WR_LOW1, ST_WR_HIGH, ST_WR_LOW2,
        ST_WA_REL, ST_WA_HIGH, ST_WA_POLL, ST_RD_LOW, ST_RD_HIGH, ST_ACK_LOW,
        ST_ACK_HIGH
    } step_t;

    step_t               step_reg, step_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [3:0]          bit_reg, bit_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [7:0]          wait_reg, wait_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                ack_reg, ack_next;
    logic [BYTE_W-1:0]   rx_reg, rx_next;

    logic                go;
    step_t               go_step;
    logic                go_scl;
    logic                go_sda;
    logic [2:0]          go_us;
    logic                fin;
    logic                fin_scl;
    logic                fin_sda;
    logic                done;
    logic                nack;
    logic [3:0]          bit_inc;
    logic [CFG_DAT_W-1:0] tpu;
    logic [10:0]         prod;

    assign tpu     = (ticks_per_us == '0) ? TICKS_RESET : ticks_per_us;
    assign prod    = 11'(go_us) * 11'(tpu);
    assign bit_inc = bit_reg + 4'd1;

    always_comb
    begin
        go      = 1'b0;
        go_step = ST_IDLE;
        go_scl  = 1'b1;
        go_sda  = 1'b1;
        go_us   = 3'd0;
        fin     = 1'b0;
        fin_scl = 1'b1;
        fin_sda = 1'b1;
        nack    = 1'b0;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        wait_next  = wait_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        delay_next = delay_reg;

        if (step_reg == ST_IDLE)
        begin
            if (op >= OP_START && op <= OP_READ)
            begin
                bit_next  = '0;
                wait_next = '0;
            end
            unique case (op)
                OP_START:
                begin
                    go = 1'b1; go_step = ST_START_A; go_scl = 1'b1; go_sda = 1'b1;
                    go_us = 3'd5;
                end
                OP_STOP:
                begin
                    go = 1'b1; go_step = ST_STOP_A; go_scl = 1'b0; go_sda = 1'b0;
                    go_us = 3'd4;
                end
                OP_WRITE:
                begin
                    shift_next = tx_byte;
                    go = 1'b1; go_step = ST_WR_LOW1; go_scl = 1'b0;
                    go_sda = tx_byte[BYTE_W-1]; go_us = 3'd2;
                end
                OP_WAIT:
                begin
                    go = 1'b1; go_step = ST_WA_REL; go_scl = scl_reg; go_sda = 1'b1;
                    go_us = 3'd1;
                end
                OP_READ:
                begin
                    shift_next = '0;
                    ack_next   = ack_after_read;
                    go = 1'b1; go_step = ST_RD_LOW; go_scl = 1'b0; go_sda = 1'b1;
                    go_us = 3'd2;
                end
                default:
                begin
                end
            endcase
        end
        else if (step_reg != ST_WA_POLL && delay_reg != '0)
        begin
            delay_next = delay_reg - 1'b1;
        end
        else
        begin
            unique case (step_reg)
                ST_START_A:
                begin
                    go = 1'b1; go_step = ST_START_B; go_scl = 1'b1; go_sda = 1'b0;
                    go_us = 3'd4;
                end
                ST_START_B:
                begin
                    fin = 1'b1; fin_scl = 1'b0; fin_sda = 1'b0;
                end
                ST_STOP_A, ST_TSTOP_A:
                begin
                    go = 1'b1;
                    go_step = (step_reg == ST_STOP_A) ? ST_STOP_B : ST_TSTOP_B;
                    go_scl = 1'b1; go_sda = 1'b0; go_us = 3'd2;
                end
                ST_STOP_B, ST_TSTOP_B:
                begin
                    go = 1'b1;
                    go_step = (step_reg == ST_STOP_B) ? ST_STOP_C : ST_TSTOP_C;
                    go_scl = 1'b1; go_sda = 1'b1; go_us = 3'd5;
                end
                ST_STOP_C:
                begin
                    fin = 1'b1; fin_scl = 1'b1; fin_sda = 1'b1;
                end
                ST_TSTOP_C:
                begin
                    fin = 1'b1; fin_scl = 1'b1; fin_sda = 1'b1;
                    nack = 1'b1;
                end
                ST_WR_LOW1:
                begin
                    go = 1'b1; go_step = ST_WR_HIGH; go_scl = 1'b1;
                    go_sda = shift_reg[BYTE_W-1]; go_us = 3'd2;
                end
                ST_WR_HIGH:
                begin
                    go = 1'b1; go_step = ST_WR_LOW2; go_scl = 1'b0;
                    go_sda = shift_reg[BYTE_W-1]; go_us = 3'd2;
                end
                ST_WR_LOW2:
                begin
                    bit_next = bit_inc;
                    if (bit_inc >= 4'd8)
                    begin
                        fin = 1'b1; fin_scl = 1'b0; fin_sda = shift_reg[BYTE_W-1];
                    end
                    else
                    begin
                        shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                        go = 1'b1; go_step = ST_WR_LOW1; go_scl = 1'b0;
                        go_sda = shift_reg[BYTE_W-2]; go_us = 3'd2;
                    end
                end
                ST_WA_REL:
                begin
                    go = 1'b1; go_step = ST_WA_HIGH; go_scl = 1'b1; go_sda = 1'b1;
                    go_us = 3'd1;
                end
                ST_WA_HIGH:
                begin
                    go = 1'b1; go_step = ST_WA_POLL; go_scl = 1'b1; go_sda = 1'b1;
                    go_us = 3'd0;
                end
                ST_WA_POLL:
                begin
                    if (!sda_level)
                    begin
                        fin = 1'b1; fin_scl = 1'b0; fin_sda = 1'b1;
                    end
                    else if (wait_reg >= ack_timeout)
                    begin
                        go = 1'b1; go_step = ST_TSTOP_A; go_scl = 1'b0; go_sda = 1'b0;
                        go_us = 3'd4;
                    end
                    else
                    begin
                        wait_next = wait_reg + 8'd1;
                    end
                end
                ST_RD_LOW:
                begin
                    shift_next = {shift_reg[BYTE_W-2:0], sda_level};
                    go = 1'b1; go_step = ST_RD_HIGH; go_scl = 1'b1; go_sda = 1'b1;
                    go_us = 3'd1;
                end
                ST_RD_HIGH:
                begin
                    bit_next = bit_inc;
                    if (bit_inc >= 4'd8)
                    begin
                        rx_next = shift_reg;
                        go = 1'b1; go_step = ST_ACK_LOW; go_scl = 1'b0;
                        go_sda = ~ack_reg; go_us = 3'd2;
                    end
                    else
                    begin
                        go = 1'b1; go_step = ST_RD_LOW; go_scl = 1'b0; go_sda = 1'b1;
                        go_us = 3'd2;
                    end
                end
                ST_ACK_LOW:
                begin
                    go = 1'b1; go_step = ST_ACK_HIGH; go_scl = 1'b1;
                    go_sda = ~ack_reg; go_us = 3'd2;
                end
                ST_ACK_HIGH:
                begin
                    fin = 1'b1; fin_scl = 1'b0; fin_sda = ~ack_reg;
                end
                default:
                begin
                    fin = 1'b1; fin_scl = 1'b1; fin_sda = 1'b1;
                end
            endcase
        end

        step_next = step_reg;
        scl_next  = scl_reg;
        sda_next  = sda_reg;
        done      = 1'b0;
        if (go)
        begin
            step_next  = go_step;
            scl_next   = go_scl;
            sda_next   = go_sda;
            delay_next = (go_us == 3'd0) ? '0 : (DELAY_W'(prod) - 1'b1);
        end
        else if (fin)
        begin
            step_next = ST_IDLE;
            scl_next  = fin_scl;
            sda_next  = fin_sda;
            done      = 1'b1;
        end
    end

    assign res.scl_level   = scl_next;
    assign res.sda_release = sda_next;
    assign res.busy_res    = (step_next != ST_IDLE);
    assign res.done_res    = done;
    assign res.rx_byte     = rx_next;
    assign res.no_ack      = nack;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            delay_reg <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            wait_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            rx_reg    <= '0;
        end
        else if (en)
        begin
            step_reg  <= step_next;
            delay_reg <= delay_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            wait_reg  <= wait_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
        end
    end

endmodule

// ----- hw/rtl/i2c_bit_level_master.sv -----
// Top level of the I2C bit-level master: stream ports, config, item registers.
//
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | s_tuser: op; s_tdata: tx_byte, ack_after_read, sda_level
// m_*      | out | m_tvalid/m_tready  | m_tdata: scl_level .. no_ack
// cfg_*    | in  | cfg_we             | cfg_addr, cfg_wdata
//
// One tick item per clock while m_tready does not stall; each item passes the input register,
// then the combinational step logic, then the result register.
// rst_n clears the sequencer to idle with both bus lines released high,
// and config to 1 tick per microsecond and an ack timeout of 250.
// A stalled m_tready holds the result; the input register takes one more item.
module i2c_bit_level_master
    import ibm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [7:0] tx_byte, [8] ack_after_read, [9] sda_level
    input  logic [OP_W-1:0]      s_tuser,   // [2:0] op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [0] scl_level, [1] sda_release, [2] busy_res,
                                            // [3] done_res, [11:4] rx_byte, [12] no_ack
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    logic                 in_valid_reg;
    logic [S_DATA_W-1:0]  in_data_reg;
    logic [OP_W-1:0]      in_op_reg;
    logic                 out_valid_reg;
    res_t                 out_reg;
    res_t                 res;
    logic                 en;
    logic                 take;
    logic [CFG_DAT_W-1:0] ticks_reg;
    logic [CFG_DAT_W-1:0] timeout_reg;

    assign en       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || en;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.no_ack, out_reg.rx_byte, out_reg.done_res,
                       out_reg.busy_res, out_reg.sda_release, out_reg.scl_level};

    ibm_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .op             (in_op_reg),
        .tx_byte        (in_data_reg[7:0]),
        .ack_after_read (in_data_reg[8]),
        .sda_level      (in_data_reg[9]),
        .ticks_per_us   (ticks_reg),
        .ack_timeout    (timeout_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg   <= TICKS_RESET;
            timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TICKS_PER_US: ticks_reg   <= cfg_wdata;
                REG_ACK_TIMEOUT:  timeout_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (en)
                in_valid_reg <= 1'b0;
            if (en)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
        if (en)
            out_reg <= res;
    end

endmodule

// ----- verif/tb_i2c_bit_level_master.sv -----
// Self-checking testbench for the I2C bit-level master: per-tick sequencer prediction.
`timescale 1ns / 100ps

module tb_i2c_bit_level_master;
    import ibm_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START_A, ST_START_B, ST_STOP_A, ST_STOP_B, ST_STOP_C,
        ST_TSTOP_A, ST_TSTOP_B, ST_TSTOP_C, ST_WR_LOW1, ST_WR_HIGH, ST_WR_LOW2,
        ST_WA_REL, ST_WA_HIGH, ST_WA_POLL, ST_RD_LOW, ST_RD_HIGH, ST_ACK_LOW,
        ST_ACK_HIGH
    } step_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;   // [7:0] tx_byte, [8] ack_after_read, [9] sda_level
    logic [OP_W-1:0]      s_tuser;   // [2:0] op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;   // [0] scl_level, [1] sda_release, [2] busy_res,
                                     // [3] done_res, [11:4] rx_byte, [12] no_ack
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    // sequencer prediction state
    step_t              sq_step  = ST_IDLE;
    logic [DELAY_W-1:0] sq_delay = '0;
    logic [3:0]         sq_bits  = '0;
    logic [BYTE_W-1:0]  sq_shift = '0;
    logic [BYTE_W-1:0]  sq_polls = '0;
    logic               sq_scl   = 1'b1;
    logic               sq_sda   = 1'b1;
    logic               sq_ack   = 1'b0;
    logic [BYTE_W-1:0]  sq_rx    = '0;
    logic [7:0]         cf_tpu   = TICKS_RESET;
    logic [7:0]         cf_tmo   = ACK_TIMEOUT_RESET;
    bit                 tick_done;
    bit                 tick_nack;

    res_t pin_expect_q[$];
    int   err_cnt     = 0;
    int   checked_cnt = 0;
    int   tick_cnt    = 0;
    int   cmd_cnt     = 0;
    int   nack_cnt    = 0;
    bit   quiet       = 1'b0;
    bit   hold_req    = 1'b0;

    i2c_bit_level_master dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        return OP_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic void go_step(step_t s, logic c, logic d, int unsigned us);
        int unsigned eff;
        eff = (cf_tpu == 8'd0) ? 1 : int'(cf_tpu);
        sq_step = s;
        sq_scl  = c;
        sq_sda  = d;
        sq_delay = (us != 0) ? DELAY_W'(us * eff - 1) : '0;
    endfunction

    function automatic void end_cmd(logic c, logic d);
        sq_step   = ST_IDLE;
        sq_scl    = c;
        sq_sda    = d;
        tick_done = 1'b1;
    endfunction

    function automatic void seq_advance(logic sdain);
        case (sq_step)
            ST_START_A: go_step(ST_START_B, 1'b1, 1'b0, 4);
            ST_START_B: end_cmd(1'b0, 1'b0);
            ST_STOP_A:  go_step(ST_STOP_B, 1'b1, 1'b0, 2);
            ST_STOP_B:  go_step(ST_STOP_C, 1'b1, 1'b1, 5);
            ST_STOP_C:  end_cmd(1'b1, 1'b1);
            ST_TSTOP_A: go_step(ST_TSTOP_B, 1'b1, 1'b0, 2);
            ST_TSTOP_B: go_step(ST_TSTOP_C, 1'b1, 1'b1, 5);
            ST_TSTOP_C:
            begin
                end_cmd(1'b1, 1'b1);
                tick_nack = 1'b1;
                nack_cnt++;
            end
            ST_WR_LOW1: go_step(ST_WR_HIGH, 1'b1, sq_shift[7], 2);
            ST_WR_HIGH: go_step(ST_WR_LOW2, 1'b0, sq_shift[7], 2);
            ST_WR_LOW2:
            begin
                sq_bits = sq_bits + 4'd1;
                if (sq_bits >= 4'd8)
                    end_cmd(1'b0, sq_shift[7]);
                else
                begin
                    sq_shift = sq_shift << 1;
                    go_step(ST_WR_LOW1, 1'b0, sq_shift[7], 2);
                end
            end
            ST_WA_REL:  go_step(ST_WA_HIGH, 1'b1, 1'b1, 1);
            ST_WA_HIGH: go_step(ST_WA_POLL, 1'b1, 1'b1, 0);
            ST_WA_POLL:
            begin
                if (!sdain)
                    end_cmd(1'b0, 1'b1);
                else if (sq_polls >= cf_tmo)
                    go_step(ST_TSTOP_A, 1'b0, 1'b0, 4);
                else
                    sq_polls = sq_polls + 8'd1;
            end
            ST_RD_LOW:
            begin
                go_step(ST_RD_HIGH, 1'b1, 1'b1, 1);
                sq_shift = {sq_shift[6:0], sdain};
            end
            ST_RD_HIGH:
            begin
                sq_bits = sq_bits + 4'd1;
                if (sq_bits >= 4'd8)
                begin
                    sq_rx = sq_shift;
                    go_step(ST_ACK_LOW, 1'b0, !sq_ack, 2);
                end
                else
                    go_step(ST_RD_LOW, 1'b0, 1'b1, 2);
            end
            ST_ACK_LOW:  go_step(ST_ACK_HIGH, 1'b1, !sq_ack, 2);
            ST_ACK_HIGH: end_cmd(1'b0, !sq_ack);
            default:     end_cmd(1'b1, 1'b1);
        endcase
    endfunction

    function automatic res_t seq_tick(logic [OP_W-1:0] op, logic [BYTE_W-1:0] tx,
                                      logic ackr, logic sdain);
        res_t r;
        tick_done = 1'b0;
        tick_nack = 1'b0;
        if (sq_step == ST_IDLE)
        begin
            if (op >= OP_START && op <= OP_READ)
            begin
                sq_bits  = '0;
                sq_polls = '0;
                cmd_cnt++;
                case (op)
                    OP_START: go_step(ST_START_A, 1'b1, 1'b1, 5);
                    OP_STOP:  go_step(ST_STOP_A, 1'b0, 1'b0, 4);
                    OP_WRITE:
                    begin
                        sq_shift = tx;
                        go_step(ST_WR_LOW1, 1'b0, tx[7], 2);
                    end
                    OP_WAIT:  go_step(ST_WA_REL, sq_scl, 1'b1, 1);
                    OP_READ:
                    begin
                        sq_shift = '0;
                        sq_ack   = ackr;
                        go_step(ST_RD_LOW, 1'b0, 1'b1, 2);
                    end
                    default: ;
                endcase
            end
        end
        else if (sq_step == ST_WA_POLL || sq_delay == '0)
            seq_advance(sdain);
        else
            sq_delay = sq_delay - 1'b1;
        r.scl_level   = sq_scl;
        r.sda_release = sq_sda;
        r.busy_res    = (sq_step != ST_IDLE);
        r.done_res    = tick_done;
        r.rx_byte     = sq_rx;
        r.no_ack      = tick_nack;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pin_expect_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none actual %h", $time, m_tdata);
                err_cnt++;
            end
            else
            begin
                want = pin_expect_q.pop_front();
                checked_cnt++;
                check_field("scl_level", want.scl_level, m_tdata[0]);
                check_field("sda_release", want.sda_release, m_tdata[1]);
                check_field("busy_res", want.busy_res, m_tdata[2]);
                check_field("done_res", want.done_res, m_tdata[3]);
                check_field("rx_byte", want.rx_byte, m_tdata[11:4]);
                check_field("no_ack", want.no_ack, m_tdata[12]);
            end
        end
    end

    initial
    begin : result_ready
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_tick(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tx,
                             input logic ackr, input logic sdain);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, sdain, ackr, tx};
        do @(posedge clk); while (!s_tready);
        pin_expect_q.push_back(seq_tick(op, tx, ackr, sdain));
        tick_cnt++;
    endtask

    // issue one command from idle and tick until it completes;
    // hi_polls high ack polls precede the low one, negative never acks
    task automatic do_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] tx,
                          input logic ackr, input logic [BYTE_W-1:0] rd_byte,
                          input int hi_polls);
        logic [BYTE_W-1:0] bits;
        int                polls;
        logic              sdain;
        bits  = rd_byte;
        polls = 0;
        send_tick(op, tx, ackr, rand_bit());
        while (sq_step != ST_IDLE)
        begin
            sdain = rand_bit();
            if (sq_step == ST_WA_POLL)
            begin
                sdain = (hi_polls < 0 || polls < hi_polls);
                polls++;
            end
            else if (sq_step == ST_RD_LOW && sq_delay == '0)
            begin
                sdain = bits[7];
                bits  = bits << 1;
            end
            send_tick(rand_op(), rand_byte(), rand_bit(), sdain);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pin_expect_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] tpu, input logic [7:0] tmo);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_TICKS_PER_US;
        cfg_wdata <= tpu;
        @(posedge clk);
        cf_tpu = tpu;
        cfg_addr  <= REG_ACK_TIMEOUT;
        cfg_wdata <= tmo;
        @(posedge clk);
        cf_tmo = tmo;
        cfg_we <= 1'b0;
    endtask

    function automatic int ack_delay();
        if ($urandom_range(0, 9) == 0)
            return -1;
        return int'($urandom_range(0, (cf_tmo < 6) ? cf_tmo : 6));
    endfunction

    task automatic test_idle_after_reset();
        do_cmd(OP_NONE, 8'hFF, 1'b1, 8'h00, 0);
        do_cmd(OP_RSVD6, 8'h00, 1'b0, 8'h00, 0);
        do_cmd(OP_RSVD7, 8'hFF, 1'b1, 8'h00, 0);
        do_cmd(OP_NONE, 8'h00, 1'b0, 8'h00, 0);
    endtask

    task automatic test_bus_sequences();
        write_regs(8'd1, 8'd3);
        do_cmd(OP_START, 8'h00, 1'b0, 8'h00, 0);
        do_cmd(OP_WRITE, 8'hA5, 1'b0, 8'h00, 0);
        do_cmd(OP_WAIT, 8'h00, 1'b0, 8'h00, 0);
        do_cmd(OP_WAIT, 8'h00, 1'b0, 8'h00, 3);
        do_cmd(OP_WAIT, 8'h00, 1'b0, 8'h00, 4);
        do_cmd(OP_READ, 8'h00, 1'b1, 8'h5A, 0);
        do_cmd(OP_READ, 8'hFF, 1'b0, 8'h81, 0);
        do_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);
        do_cmd(OP_WAIT, 8'h00, 1'b0, 8'h00, 0);
    endtask

    task automatic test_tick_scale();
        write_regs(8'd0, 8'd0);
        do_cmd(OP_START, 8'h00, 1'b0, 8'h00, 0);
        do_cmd(OP_WRITE, 8'h3C, 1'b0, 8'h00, 0);
        do_cmd(OP_WAIT, 8'h00, 1'b0, 8'h00, 0);
        do_cmd(OP_WAIT, 8'h00, 1'b0, 8'h00, 1);
        do_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);
        write_regs(8'd40, 8'd5);
        do_cmd(OP_WAIT, 8'h00, 1'b0, 8'h00, 2);
        write_regs(8'd1, 8'd40);
        do_cmd(OP_WAIT, 8'h00, 1'b0, 8'h00, -1);
    endtask

    task automatic test_backpressure();
        write_regs(8'd2, 8'd5);
        hold_req = 1'b1;
        do_cmd(OP_START, 8'h00, 1'b0, 8'h00, 0);
        do_cmd(OP_WAIT, 8'h00, 1'b0, 8'h00, 1);
        do_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);
    endtask

    // mostly well-formed transfers with random content, some stray commands
    task automatic test_random_traffic(input logic [7:0] tpu, input logic [7:0] tmo,
                                       input int n_ticks);
        int target;
        int n;
        write_regs(tpu, tmo);
        target = tick_cnt + n_ticks;
        while (tick_cnt < target)
        begin
            if ($urandom_range(0, 4) == 0)
                do_cmd(rand_op(), rand_byte(), rand_bit(), rand_byte(), ack_delay());
            else
            begin
                do_cmd(OP_START, rand_byte(), rand_bit(), rand_byte(), 0);
                do_cmd(OP_WRITE, rand_byte(), rand_bit(), rand_byte(), 0);
                do_cmd(OP_WAIT, rand_byte(), rand_bit(), rand_byte(), ack_delay());
                n = $urandom_range(0, 1);
                repeat (n)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        do_cmd(OP_WRITE, rand_byte(), rand_bit(), rand_byte(), 0);
                        do_cmd(OP_WAIT, rand_byte(), rand_bit(), rand_byte(), ack_delay());
                    end
                    else
                        do_cmd(OP_READ, rand_byte(), rand_bit(), rand_byte(), 0);
                end
                do_cmd(OP_STOP, rand_byte(), rand_bit(), rand_byte(), 0);
            end
        end
    endtask

    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_NONE;
        cfg_we    = 1'b0;
        cfg_addr  = REG_TICKS_PER_US;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_after_reset();
        test_bus_sequences();
        test_tick_scale();
        test_backpressure();
        test_random_traffic(8'd1, 8'd0, 60);
        test_random_traffic(8'd1, 8'($urandom_range(0, 7)), 60);
        quiet = 1'b1;
        test_random_traffic(8'd1, 8'd2, 60);
        settle();

        $display("Run covered %0d commands (%0d ack timeouts) over %0d ticks,",
                 cmd_cnt, nack_cnt, tick_cnt);
        $display("with %0d result items checked across several tick scales and timeouts.",
                 checked_cnt);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
